// File: rtl/core/fdsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdsm_pkg
// shared widths, register indexes and record types of the fall detector
// ----------------------------------------------------------------------------
package fdsm_pkg;

   localparam int ACCEL_W   = 15;
   localparam int GYRO_W    = 22;
   localparam int ALT_W     = 21;
   localparam int TIME_W    = 32;
   localparam int AMAG_W    = 30;
   localparam int GMAG_W    = 44;
   localparam int LIMIT_W   = 17;
   localparam int WAIT_W    = 16;
   localparam int DROP_W    = 21;
   localparam int CSR_W     = 44;
   localparam int CSR_IDX_W = 3;
   localparam int AVG_TAPS  = 4;
   localparam int SLOT_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTLESS_LEVEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPACT_LEVEL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_LEVEL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TUMBLE_LEVEL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_LEVEL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DROP         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT_RATE_LIMIT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INACTIVE_WAIT    = 3'd7;

   typedef struct packed {
      logic [AMAG_W-1:0]  weightless_level_sq;
      logic [AMAG_W-1:0]  impact_level_sq;
      logic [AMAG_W-1:0]  moving_level_sq;
      logic [GMAG_W-1:0]  tumble_level_sq;
      logic [GMAG_W-1:0]  still_level_sq;
      logic [LIMIT_W-1:0] min_drop_cm;
      logic [LIMIT_W-1:0] alt_rate_limit;
      logic [WAIT_W-1:0]  inactive_wait_ms;
   } csr_type;

   // classified sample handed from front to back
   typedef struct packed {
      logic                    weightless_hit;
      logic                    impact_hit;
      logic                    not_moving;
      logic                    tumble_hit;
      logic                    still_hit;
      logic                    rapid_hit;
      logic signed [ALT_W-1:0] altitude_cm;
      logic [TIME_W-1:0]       time_ms;
   } item_type;

   // window sum divided by four, truncated toward zero
   function automatic logic signed [ACCEL_W-1:0] avg4(input logic signed [ACCEL_W+1:0] s);
      logic signed [ACCEL_W+1:0] t;
      t = s[ACCEL_W+1] ? s + (ACCEL_W+2)'(3) : s;
      return ACCEL_W'(t >>> 2);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/fdsm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdsm_req_if / fdsm_rsp_if
// valid/ready channels for sensor requests and detector results
// ----------------------------------------------------------------------------
interface fdsm_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] accel_x;
   logic signed [14:0] accel_y;
   logic signed [14:0] accel_z;
   logic signed [21:0] gyro_x;
   logic signed [21:0] gyro_y;
   logic signed [21:0] gyro_z;
   logic signed [20:0] altitude_cm;
   logic [31:0]        time_ms;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   altitude_cm, time_ms, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 altitude_cm, time_ms, output ready);
endinterface

interface fdsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  fall_mode;
   logic        tumble_seen;
   logic        rapid_alt_seen;
   logic [20:0] max_drop_cm;
   logic        fast_blink;
   logic        buzzer_on;
   modport source (output valid, fall_mode, tumble_seen, rapid_alt_seen, max_drop_cm,
                   fast_blink, buzzer_on, input ready);
   modport sink (input valid, fall_mode, tumble_seen, rapid_alt_seen, max_drop_cm,
                 fast_blink, buzzer_on, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fdsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdsm_front
// accel averaging, altitude rate and squared magnitude classification
// ----------------------------------------------------------------------------
module fdsm_front #(
   parameter int RATE_WINDOW_MS = 500
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fdsm_req_if.sink               req,
   input  wire fdsm_pkg::csr_type csr,
   output logic                   item_valid,
   output fdsm_pkg::item_type     item,
   input  wire logic              item_ready
);
   import fdsm_pkg::*;

   logic adv0, adv1, take;

   // stage 0 state
   logic signed [ACCEL_W-1:0] win_x_ff [AVG_TAPS];
   logic signed [ACCEL_W-1:0] win_y_ff [AVG_TAPS];
   logic signed [ACCEL_W-1:0] win_z_ff [AVG_TAPS];
   logic [SLOT_W-1:0]         slot_ff;
   logic                      primed_ff;
   logic signed [ALT_W-1:0]   prev_alt_ff;
   logic [TIME_W-1:0]         prev_time_ff;
   logic signed [ALT_W:0]     held_delta_ff, held_delta_in;
   logic [TIME_W-1:0]         held_dt_ff, held_dt_in;

   logic signed [ACCEL_W+1:0] sum_x, sum_y, sum_z;
   logic [TIME_W-1:0]         dt;
   logic                      new_window;
   logic [ALT_W:0]            absd;

   // stage 0 -> 1
   logic                      p0_valid_ff;
   logic signed [ACCEL_W-1:0] p0_ax_ff, p0_ay_ff, p0_az_ff;
   logic signed [GYRO_W-1:0]  p0_gx_ff, p0_gy_ff, p0_gz_ff;
   logic signed [ALT_W-1:0]   p0_alt_ff;
   logic [TIME_W-1:0]         p0_time_ff;
   logic [ALT_W:0]            p0_absd_ff;
   logic [TIME_W-1:0]         p0_dt_ff;

   // stage 1 -> out
   logic                      p1_valid_ff;
   logic [2*ACCEL_W-1:0]      p1_ax_ff, p1_ay_ff, p1_az_ff;
   logic [2*GYRO_W-1:0]       p1_gx_ff, p1_gy_ff, p1_gz_ff;
   logic signed [ALT_W-1:0]   p1_alt_ff;
   logic [TIME_W-1:0]         p1_time_ff;
   logic [TIME_W-1:0]         p1_dk_ff;
   logic [LIMIT_W+TIME_W-1:0] p1_ld_ff;

   logic signed [2*ACCEL_W-1:0] sq_ax, sq_ay, sq_az;
   logic signed [2*GYRO_W-1:0]  sq_gx, sq_gy, sq_gz;
   logic [AMAG_W+1:0]           amag;
   logic [2*GYRO_W+1:0]         gmag;

   assign adv1      = !p1_valid_ff || item_ready;
   assign adv0      = !p0_valid_ff || adv1;
   assign req.ready = adv0;
   assign take      = req.valid && adv0;

   always_comb begin
      sum_x = (ACCEL_W+2)'(0);
      sum_y = (ACCEL_W+2)'(0);
      sum_z = (ACCEL_W+2)'(0);
      for (int k = 0; k < AVG_TAPS; k++) begin
         if (slot_ff == SLOT_W'(k)) begin
            sum_x = sum_x + (ACCEL_W+2)'(req.accel_x);
            sum_y = sum_y + (ACCEL_W+2)'(req.accel_y);
            sum_z = sum_z + (ACCEL_W+2)'(req.accel_z);
         end else begin
            sum_x = sum_x + (ACCEL_W+2)'(win_x_ff[k]);
            sum_y = sum_y + (ACCEL_W+2)'(win_y_ff[k]);
            sum_z = sum_z + (ACCEL_W+2)'(win_z_ff[k]);
         end
      end
   end

   always_comb begin
      dt            = req.time_ms - prev_time_ff;
      new_window    = primed_ff && (dt >= TIME_W'(RATE_WINDOW_MS));
      held_delta_in = held_delta_ff;
      held_dt_in    = held_dt_ff;
      if (new_window) begin
         held_delta_in = (ALT_W+1)'(req.altitude_cm) - (ALT_W+1)'(prev_alt_ff);
         held_dt_in    = dt;
      end
      absd = held_delta_in[ALT_W] ? (ALT_W+1)'(0) - held_delta_in : held_delta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AVG_TAPS; k++) begin
            win_x_ff[k] <= '0;
            win_y_ff[k] <= '0;
            win_z_ff[k] <= '0;
         end
         slot_ff       <= '0;
         primed_ff     <= 1'b0;
         prev_alt_ff   <= '0;
         prev_time_ff  <= '0;
         held_delta_ff <= '0;
         held_dt_ff    <= TIME_W'(1);
      end else if (take) begin
         win_x_ff[slot_ff] <= req.accel_x;
         win_y_ff[slot_ff] <= req.accel_y;
         win_z_ff[slot_ff] <= req.accel_z;
         slot_ff           <= slot_ff + SLOT_W'(1);
         primed_ff         <= 1'b1;
         held_delta_ff     <= held_delta_in;
         held_dt_ff        <= held_dt_in;
         if (!primed_ff || new_window) begin
            prev_alt_ff  <= req.altitude_cm;
            prev_time_ff <= req.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else begin
         if (adv0) p0_valid_ff <= req.valid;
         if (adv1) p1_valid_ff <= p0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         p0_ax_ff   <= avg4(sum_x);
         p0_ay_ff   <= avg4(sum_y);
         p0_az_ff   <= avg4(sum_z);
         p0_gx_ff   <= req.gyro_x;
         p0_gy_ff   <= req.gyro_y;
         p0_gz_ff   <= req.gyro_z;
         p0_alt_ff  <= req.altitude_cm;
         p0_time_ff <= req.time_ms;
         p0_absd_ff <= absd;
         p0_dt_ff   <= held_dt_in;
      end
   end

   always_comb begin
      sq_ax = p0_ax_ff * p0_ax_ff;
      sq_ay = p0_ay_ff * p0_ay_ff;
      sq_az = p0_az_ff * p0_az_ff;
      sq_gx = p0_gx_ff * p0_gx_ff;
      sq_gy = p0_gy_ff * p0_gy_ff;
      sq_gz = p0_gz_ff * p0_gz_ff;
   end

   always_ff @(posedge clock) begin
      if (adv1 && p0_valid_ff) begin
         p1_ax_ff   <= sq_ax;
         p1_ay_ff   <= sq_ay;
         p1_az_ff   <= sq_az;
         p1_gx_ff   <= sq_gx;
         p1_gy_ff   <= sq_gy;
         p1_gz_ff   <= sq_gz;
         p1_alt_ff  <= p0_alt_ff;
         p1_time_ff <= p0_time_ff;
         p1_dk_ff   <= TIME_W'(p0_absd_ff) * TIME_W'(1000);
         p1_ld_ff   <= (LIMIT_W+TIME_W)'(csr.alt_rate_limit)
                       * (LIMIT_W+TIME_W)'(p0_dt_ff);
      end
   end

   always_comb begin
      amag = (AMAG_W+2)'(p1_ax_ff) + (AMAG_W+2)'(p1_ay_ff) + (AMAG_W+2)'(p1_az_ff);
      gmag = (2*GYRO_W+2)'(p1_gx_ff) + (2*GYRO_W+2)'(p1_gy_ff)
             + (2*GYRO_W+2)'(p1_gz_ff);
      item_valid          = p1_valid_ff;
      item.weightless_hit = amag < (AMAG_W+2)'(csr.weightless_level_sq);
      item.impact_hit     = amag > (AMAG_W+2)'(csr.impact_level_sq);
      item.not_moving     = amag < (AMAG_W+2)'(csr.moving_level_sq);
      item.tumble_hit     = gmag > (2*GYRO_W+2)'(csr.tumble_level_sq);
      item.still_hit      = gmag < (2*GYRO_W+2)'(csr.still_level_sq);
      item.rapid_hit      = (LIMIT_W+TIME_W)'(p1_dk_ff) > p1_ld_ff;
      item.altitude_cm    = p1_alt_ff;
      item.time_ms        = p1_time_ff;
   end

endmodule
`default_nettype wire

// File: rtl/core/fdsm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdsm_queue
// two-entry queue between classification and the state machine
// ----------------------------------------------------------------------------
module fdsm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_valid,
   input  wire fdsm_pkg::item_type wr_item,
   output logic                    wr_ready,
   output logic                    rd_valid,
   output fdsm_pkg::item_type      rd_item,
   input  wire logic               rd_ready
);
   import fdsm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign wr_ready = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/fdsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdsm_back
// fall state machine and result register
// ----------------------------------------------------------------------------
module fdsm_back #(
   parameter int WEIGHTLESS_TIMEOUT_MS = 2000
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fdsm_pkg::csr_type  csr,
   input  wire logic               item_valid,
   input  wire fdsm_pkg::item_type item,
   output logic                    item_ready,
   fdsm_rsp_if.source              rsp
);
   import fdsm_pkg::*;

   typedef enum logic [1:0] {
      IDLE        = 2'd0,
      WEIGHTLESS  = 2'd1,
      POST_IMPACT = 2'd2,
      FALLEN      = 2'd3
   } state_type;

   state_type               state_ff, state_in;
   logic                    tumble_ff, tumble_in;
   logic                    rapid_ff, rapid_in;
   logic signed [ALT_W-1:0] start_alt_ff, start_alt_in;
   logic [DROP_W-1:0]       drop_max_ff, drop_max_in;
   logic [TIME_W-1:0]       phase_ff, phase_in;
   logic                    out_valid_ff;
   logic signed [ALT_W:0]   drop;
   logic [TIME_W-1:0]       elapsed;
   logic                    fire;

   assign item_ready = !out_valid_ff || rsp.ready;
   assign fire       = item_valid && item_ready;
   assign rsp.valid  = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      tumble_in    = tumble_ff;
      rapid_in     = rapid_ff;
      start_alt_in = start_alt_ff;
      drop_max_in  = drop_max_ff;
      phase_in     = phase_ff;
      drop         = (ALT_W+1)'(start_alt_ff) - (ALT_W+1)'(item.altitude_cm);
      elapsed      = item.time_ms - phase_ff;
      case (state_ff)
         IDLE: begin
            tumble_in    = 1'b0;
            rapid_in     = 1'b0;
            drop_max_in  = '0;
            start_alt_in = item.altitude_cm;
            if (item.weightless_hit) begin
               state_in = WEIGHTLESS;
               phase_in = item.time_ms;
            end
         end
         WEIGHTLESS: begin
            if (item.rapid_hit) rapid_in = 1'b1;
            if (item.impact_hit) begin
               phase_in    = item.time_ms;
               drop_max_in = '0;
               state_in    = POST_IMPACT;
            end else if (elapsed > TIME_W'(WEIGHTLESS_TIMEOUT_MS)) begin
               state_in = IDLE;
            end
         end
         POST_IMPACT: begin
            if (item.tumble_hit) tumble_in = 1'b1;
            if (item.rapid_hit)  rapid_in  = 1'b1;
            if (drop > $signed({1'b0, drop_max_ff})) drop_max_in = DROP_W'(drop);
            if (elapsed >= TIME_W'(csr.inactive_wait_ms)) begin
               // all evidence must agree for a confirmed fall
               if (item.still_hit && tumble_in && rapid_in && item.not_moving
                   && (drop_max_in >= DROP_W'(csr.min_drop_cm)))
                  state_in = FALLEN;
               else
                  state_in = IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         tumble_ff    <= 1'b0;
         rapid_ff     <= 1'b0;
         start_alt_ff <= '0;
         drop_max_ff  <= '0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            state_ff           <= state_in;
            tumble_ff          <= tumble_in;
            rapid_ff           <= rapid_in;
            start_alt_ff       <= start_alt_in;
            drop_max_ff        <= drop_max_in;
            phase_ff           <= phase_in;
            rsp.fall_mode      <= 2'(state_in);
            rsp.tumble_seen    <= tumble_in;
            rsp.rapid_alt_seen <= rapid_in;
            rsp.max_drop_cm    <= drop_max_in;
            rsp.fast_blink     <= (state_in == POST_IMPACT) || (state_in == FALLEN);
            rsp.buzzer_on      <= state_in == FALLEN;
         end
         if (fire)           out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/fall_detection_state_machine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fall_detection_state_machine_unit
// fall detector on accel, gyro, altitude and timestamp samples
// ----------------------------------------------------------------------------
// usage
//   req carries one sensor sample per request (valid/ready); rsp returns one
//   result per request in order: mode, tumble and rapid flags, max drop,
//   blink speed and buzzer, all as they stand after that sample
//   csr_we/csr_index/csr_wdata write the eight thresholds; write only while idle
// timing
//   four register stages: averaging and rate window, then the squaring
//   multipliers, then the magnitude compares into the queue, then the state
//   machine into the result register
//   one request per cycle sustained while rsp.ready stays high; the throughput
//   is set by the single state machine update per cycle
// reset
//   synchronous; clears windows, rate history, state (idle) and the queue,
//   and loads the threshold defaults
// stalls
//   when rsp is held off, the result register keeps its value, the queue
//   takes up to two samples, then the front stages fill and req.ready drops
// ----------------------------------------------------------------------------
module fall_detection_state_machine_unit #(
   parameter int WEIGHTLESS_TIMEOUT_MS = 2000,
   parameter int RATE_WINDOW_MS        = 500
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fdsm_req_if.sink                               req,
   fdsm_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [fdsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fdsm_pkg::CSR_W-1:0]        csr_wdata
);
   import fdsm_pkg::*;

   csr_type  csr_ff;
   logic     front_valid, queue_ready, back_valid, back_ready;
   item_type front_item, back_item;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.weightless_level_sq <= AMAG_W'(93711);
         csr_ff.impact_level_sq     <= AMAG_W'(1626913);
         csr_ff.moving_level_sq     <= AMAG_W'(1192115);
         csr_ff.tumble_level_sq     <= GMAG_W'(64'd22500000000);
         csr_ff.still_level_sq      <= GMAG_W'(900000000);
         csr_ff.min_drop_cm         <= LIMIT_W'(40);
         csr_ff.alt_rate_limit      <= LIMIT_W'(30);
         csr_ff.inactive_wait_ms    <= WAIT_W'(5000);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WEIGHTLESS_LEVEL: csr_ff.weightless_level_sq <= csr_wdata[AMAG_W-1:0];
            CSR_IMPACT_LEVEL:     csr_ff.impact_level_sq     <= csr_wdata[AMAG_W-1:0];
            CSR_MOVING_LEVEL:     csr_ff.moving_level_sq     <= csr_wdata[AMAG_W-1:0];
            CSR_TUMBLE_LEVEL:     csr_ff.tumble_level_sq     <= csr_wdata[GMAG_W-1:0];
            CSR_STILL_LEVEL:      csr_ff.still_level_sq      <= csr_wdata[GMAG_W-1:0];
            CSR_MIN_DROP:         csr_ff.min_drop_cm         <= csr_wdata[LIMIT_W-1:0];
            CSR_ALT_RATE_LIMIT:   csr_ff.alt_rate_limit      <= csr_wdata[LIMIT_W-1:0];
            CSR_INACTIVE_WAIT:    csr_ff.inactive_wait_ms    <= csr_wdata[WAIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: averaging, rate window, squared magnitudes
   fdsm_front #(
      .RATE_WINDOW_MS (RATE_WINDOW_MS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr_ff),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (queue_ready)
   );

   // decoupling queue
   fdsm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_item  (front_item),
      .wr_ready (queue_ready),
      .rd_valid (back_valid),
      .rd_item  (back_item),
      .rd_ready (back_ready)
   );

   // back: fall state machine and result register
   fdsm_back #(
      .WEIGHTLESS_TIMEOUT_MS (WEIGHTLESS_TIMEOUT_MS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .item_valid (back_valid),
      .item       (back_item),
      .item_ready (back_ready),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire

// File: verif/tb_fall_detection_state_machine_unit.sv
// ----------------------------------------------------------------------------
// tb_fall_detection_state_machine_unit
// self-checking bench for the fall detector: drives sensor requests built as
// free fall / impact / wait sequences plus random noise, predicts every result
// cycle-free in a scoreboard class and compares all fields in order
// ----------------------------------------------------------------------------
module tb_fall_detection_state_machine_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import fdsm_pkg::*;

   // timing constants of the detector, as built with its default parameters
   localparam int WEIGHTLESS_TIMEOUT_MS = 2000;
   localparam int RATE_WINDOW_MS        = 500;
   localparam int SETTLE_CYCLES         = 8;     // pipeline is four deep
   localparam int WATCHDOG_LIMIT        = 5000;

   typedef enum logic [1:0] {
      FALL_IDLE        = 2'd0,
      FALL_WEIGHTLESS  = 2'd1,
      FALL_POST_IMPACT = 2'd2,
      FALL_FALLEN      = 2'd3
   } fall_mode_type;

   typedef struct {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic signed [GYRO_W-1:0]  gyro_x;
      logic signed [GYRO_W-1:0]  gyro_y;
      logic signed [GYRO_W-1:0]  gyro_z;
      logic signed [ALT_W-1:0]   altitude_cm;
      logic [TIME_W-1:0]         time_ms;
   } sensor_sample_type;

   typedef struct {
      fall_mode_type    mode;
      bit               tumble;
      bit               rapid;
      bit [DROP_W-1:0]  max_drop;
      bit               fast_blink;
      bit               buzzer;
   } fall_status_type;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of the detector state, predicts one status per
   // request and checks results against the oldest prediction
   // -------------------------------------------------------------------------
   class fall_status_scoreboard;
      logic [CSR_W-1:0] thresholds [8];
      int               win_x [4];
      int               win_y [4];
      int               win_z [4];
      int               slot;
      fall_mode_type    mode;
      bit               tumble;
      bit               rapid;
      int               start_alt;
      int               drop_max;
      bit [31:0]        phase_start;
      bit               rate_primed;
      int               prev_alt;
      bit [31:0]        prev_time;
      int               held_delta;
      bit [31:0]        held_dt;
      fall_status_type  pending [$];
      int               errors;

      function new();
         thresholds[CSR_WEIGHTLESS_LEVEL] = 93711;
         thresholds[CSR_IMPACT_LEVEL]     = 1626913;
         thresholds[CSR_MOVING_LEVEL]     = 1192115;
         thresholds[CSR_TUMBLE_LEVEL]     = 44'd22500000000;
         thresholds[CSR_STILL_LEVEL]      = 900000000;
         thresholds[CSR_MIN_DROP]         = 40;
         thresholds[CSR_ALT_RATE_LIMIT]   = 30;
         thresholds[CSR_INACTIVE_WAIT]    = 5000;
         for (int k = 0; k < 4; k++) begin
            win_x[k] = 0;
            win_y[k] = 0;
            win_z[k] = 0;
         end
         slot        = 0;
         mode        = FALL_IDLE;
         tumble      = 0;
         rapid       = 0;
         start_alt   = 0;
         drop_max    = 0;
         phase_start = 0;
         rate_primed = 0;
         prev_alt    = 0;
         prev_time   = 0;
         held_delta  = 0;
         held_dt     = 1;
         errors      = 0;
      endfunction

      function void write_threshold(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         int w;
         case (idx)
            CSR_WEIGHTLESS_LEVEL, CSR_IMPACT_LEVEL, CSR_MOVING_LEVEL: w = AMAG_W;
            CSR_TUMBLE_LEVEL, CSR_STILL_LEVEL:                        w = GMAG_W;
            CSR_MIN_DROP, CSR_ALT_RATE_LIMIT:                         w = LIMIT_W;
            default:                                                  w = WAIT_W;
         endcase
         thresholds[idx] = value & CSR_W'((64'd1 << w) - 64'd1);
      endfunction

      function int average4(int a, int b, int c, int d);
         return (a + b + c + d) / 4;
      endfunction

      function void note_request(sensor_sample_type s);
         int                alt;
         bit [31:0]         now;
         bit [31:0]         dt;
         bit [31:0]         since;
         longint            avx, avy, avz, gx, gy, gz;
         longint unsigned   amag, gmag, absd;
         bit                rapid_now;
         int                drop;
         fall_status_type   st;

         alt = s.altitude_cm;
         now = s.time_ms;

         // altitude rate, refreshed only once the window has passed
         if (!rate_primed) begin
            rate_primed = 1;
            prev_alt    = alt;
            prev_time   = now;
         end else begin
            dt = now - prev_time;
            if (dt >= RATE_WINDOW_MS) begin
               held_delta = alt - prev_alt;
               held_dt    = dt;
               prev_alt   = alt;
               prev_time  = now;
            end
         end
         absd = (held_delta < 0) ? longint'(-held_delta) : longint'(held_delta);
         rapid_now = absd * 1000 > 64'(thresholds[CSR_ALT_RATE_LIMIT]) * 64'(held_dt);

         win_x[slot] = s.accel_x;
         win_y[slot] = s.accel_y;
         win_z[slot] = s.accel_z;
         slot = (slot + 1) % 4;

         avx  = average4(win_x[0], win_x[1], win_x[2], win_x[3]);
         avy  = average4(win_y[0], win_y[1], win_y[2], win_y[3]);
         avz  = average4(win_z[0], win_z[1], win_z[2], win_z[3]);
         gx   = s.gyro_x;
         gy   = s.gyro_y;
         gz   = s.gyro_z;
         amag = avx * avx + avy * avy + avz * avz;
         gmag = gx * gx + gy * gy + gz * gz;
         since = now - phase_start;

         case (mode)
            FALL_IDLE: begin
               tumble    = 0;
               rapid     = 0;
               drop_max  = 0;
               start_alt = alt;
               if (amag < 64'(thresholds[CSR_WEIGHTLESS_LEVEL])) begin
                  mode        = FALL_WEIGHTLESS;
                  phase_start = now;
               end
            end
            FALL_WEIGHTLESS: begin
               if (rapid_now) rapid = 1;
               if (amag > 64'(thresholds[CSR_IMPACT_LEVEL])) begin
                  phase_start = now;
                  drop_max    = 0;
                  mode        = FALL_POST_IMPACT;
               end else if (since > WEIGHTLESS_TIMEOUT_MS) begin
                  mode = FALL_IDLE;
               end
            end
            FALL_POST_IMPACT: begin
               drop = start_alt - alt;
               if (gmag > 64'(thresholds[CSR_TUMBLE_LEVEL])) tumble = 1;
               if (rapid_now) rapid = 1;
               if (drop > drop_max) drop_max = drop;
               if (64'(since) >= 64'(thresholds[CSR_INACTIVE_WAIT])) begin
                  if (gmag < 64'(thresholds[CSR_STILL_LEVEL]) && tumble
                      && 64'(drop_max) >= 64'(thresholds[CSR_MIN_DROP]) && rapid
                      && amag < 64'(thresholds[CSR_MOVING_LEVEL]))
                     mode = FALL_FALLEN;
                  else
                     mode = FALL_IDLE;
               end
            end
            default: ;
         endcase

         st.mode       = mode;
         st.tumble     = tumble;
         st.rapid      = rapid;
         st.max_drop   = drop_max[DROP_W-1:0];
         st.fast_blink = (mode == FALL_POST_IMPACT || mode == FALL_FALLEN);
         st.buzzer     = (mode == FALL_FALLEN);
         pending.push_back(st);
      endfunction

      task report_mismatch(string what, longint want, longint got);
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
         errors++;
      endtask

      task check_result(fall_status_type got);
         fall_status_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result, mode", -1, got.mode);
         end else begin
            want = pending.pop_front();
            if (got.mode != want.mode) report_mismatch("fall_mode", want.mode, got.mode);
            if (got.tumble != want.tumble)
               report_mismatch("tumble_seen", want.tumble, got.tumble);
            if (got.rapid != want.rapid)
               report_mismatch("rapid_alt_seen", want.rapid, got.rapid);
            if (got.max_drop != want.max_drop)
               report_mismatch("max_drop_cm", want.max_drop, got.max_drop);
            if (got.fast_blink != want.fast_blink)
               report_mismatch("fast_blink", want.fast_blink, got.fast_blink);
            if (got.buzzer != want.buzzer)
               report_mismatch("buzzer_on", want.buzzer, got.buzzer);
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   fdsm_req_if req_ch ();
   fdsm_rsp_if rsp_ch ();

   fall_detection_state_machine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fall_status_scoreboard sb = new();

   bit [31:0] now_ms;      // running timestamp of the generated samples
   int        alt_level;   // running altitude of the generated samples
   bit        calm;        // no idling on either side in the last part
   int        sent;        // accepted requests so far
   int        idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // result side: random stall bursts on ready, monitor on accept
   // -------------------------------------------------------------------------
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (calm) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 40)) begin
               rsp_ch.ready <= 1'b1;
               @(posedge clock);
            end
            repeat ($urandom_range(1, 13)) begin
               rsp_ch.ready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      fall_status_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.mode       = fall_mode_type'(rsp_ch.fall_mode);
         got.tumble     = rsp_ch.tumble_seen;
         got.rapid      = rsp_ch.rapid_alt_seen;
         got.max_drop   = rsp_ch.max_drop_cm;
         got.fast_blink = rsp_ch.fast_blink;
         got.buzzer     = rsp_ch.buzzer_on;
         sb.check_result(got);
      end
   end

   // watchdog: counts cycles in which neither channel moves
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   function automatic sensor_sample_type make_sample(int ax, int ay, int az, int gx, int gy,
                                                     int gz, int alt, bit [31:0] t);
      sensor_sample_type s;
      s.accel_x     = ACCEL_W'(ax);
      s.accel_y     = ACCEL_W'(ay);
      s.accel_z     = ACCEL_W'(az);
      s.gyro_x      = GYRO_W'(gx);
      s.gyro_y      = GYRO_W'(gy);
      s.gyro_z      = GYRO_W'(gz);
      s.altitude_cm = ALT_W'(alt);
      s.time_ms     = t;
      return s;
   endfunction

   // one request, optionally after a random gap; returns on acceptance
   task automatic send_sample(sensor_sample_type s);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.accel_x     <= s.accel_x;
      req_ch.accel_y     <= s.accel_y;
      req_ch.accel_z     <= s.accel_z;
      req_ch.gyro_x      <= s.gyro_x;
      req_ch.gyro_y      <= s.gyro_y;
      req_ch.gyro_z      <= s.gyro_z;
      req_ch.altitude_cm <= s.altitude_cm;
      req_ch.time_ms     <= s.time_ms;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(s);
      sent++;
   endtask

   // all fields random over their full width, but the timestamp half the time just ahead of now_ms
   task automatic send_noise();
      sensor_sample_type s;
      s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
      if ($urandom_range(0, 1)) s.time_ms = now_ms + $urandom_range(0, 900);
      now_ms = s.time_ms;
      send_sample(s);
   endtask

   // well-formed event: free fall, impact, post-impact wait, final decision sample
   task automatic send_fall_attempt();
      int n_fall;
      int n_hit;
      int n_wait;
      int big;
      if ($urandom_range(0, 39) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      if (alt_level < -90000 || alt_level > 990000) alt_level = $urandom_range(0, 500000);
      n_fall = $urandom_range(3, 7);
      n_hit  = $urandom_range(1, 3);
      n_wait = $urandom_range(2, 10);
      // near-zero gravity while falling, altitude dropping
      repeat (n_fall) begin
         now_ms    = now_ms + $urandom_range(60, 400);
         alt_level = alt_level - $urandom_range(0, 300);
         send_sample(make_sample(int'($urandom_range(300)) - 150,
                                 int'($urandom_range(300)) - 150,
                                 int'($urandom_range(300)) - 150,
                                 int'($urandom_range(100000)) - 50000,
                                 int'($urandom_range(100000)) - 50000,
                                 int'($urandom_range(100000)) - 50000,
                                 alt_level, now_ms));
      end
      // impact: a large spike on some axis
      repeat (n_hit) begin
         now_ms = now_ms + $urandom_range(10, 200);
         big    = $urandom_range(3000, 16000);
         if ($urandom_range(0, 1)) big = -big;
         send_sample(make_sample(($urandom_range(0, 2) == 0) ? big : 0,
                                 ($urandom_range(0, 2) == 1) ? big : 0,
                                 ($urandom_range(0, 2) == 2) ? big : big / 2,
                                 int'($urandom_range(4000000)) - 2000000,
                                 int'($urandom_range(4000000)) - 2000000,
                                 int'($urandom_range(4000000)) - 2000000,
                                 alt_level, now_ms));
      end
      // lying on the ground, sometimes rolling
      repeat (n_wait) begin
         now_ms    = now_ms + $urandom_range(200, 1500);
         alt_level = alt_level - int'($urandom_range(60)) + 20;
         big       = $urandom_range(0, 1) ? $urandom_range(200000, 2000000) : 0;
         send_sample(make_sample(int'($urandom_range(160)) - 80,
                                 int'($urandom_range(160)) - 80,
                                 1000 + int'($urandom_range(160)) - 80,
                                 big, int'($urandom_range(30000)) - 15000,
                                 int'($urandom_range(30000)) - 15000,
                                 alt_level, now_ms));
      end
      now_ms = now_ms + $urandom_range(0, 6000);
      send_sample(make_sample(int'($urandom_range(160)) - 80,
                              int'($urandom_range(160)) - 80,
                              1000 + int'($urandom_range(160)) - 80,
                              int'($urandom_range(30000)) - 15000,
                              int'($urandom_range(30000)) - 15000,
                              int'($urandom_range(30000)) - 15000,
                              alt_level, now_ms));
   endtask

   task automatic run_random(int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         if ($urandom_range(0, 9) < 7) send_fall_attempt();
         else repeat ($urandom_range(1, 5)) send_noise();
      end
   endtask

   // drain all outstanding requests before touching the thresholds
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_threshold(idx, value);
   endtask

   task automatic load_thresholds(logic [CSR_W-1:0] ff, logic [CSR_W-1:0] imp,
                                  logic [CSR_W-1:0] mov, logic [CSR_W-1:0] tum,
                                  logic [CSR_W-1:0] still, logic [CSR_W-1:0] drop,
                                  logic [CSR_W-1:0] rate, logic [CSR_W-1:0] waitms);
      wait_drained();
      write_csr(CSR_WEIGHTLESS_LEVEL, ff);
      write_csr(CSR_IMPACT_LEVEL, imp);
      write_csr(CSR_MOVING_LEVEL, mov);
      write_csr(CSR_TUMBLE_LEVEL, tum);
      write_csr(CSR_STILL_LEVEL, still);
      write_csr(CSR_MIN_DROP, drop);
      write_csr(CSR_ALT_RATE_LIMIT, rate);
      write_csr(CSR_INACTIVE_WAIT, waitms);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   localparam logic [CSR_W-1:0] ALL_ONES = '1;

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.accel_x     <= '0;
      req_ch.accel_y     <= '0;
      req_ch.accel_z     <= '0;
      req_ch.gyro_x      <= '0;
      req_ch.gyro_y      <= '0;
      req_ch.gyro_z      <= '0;
      req_ch.altitude_cm <= '0;
      req_ch.time_ms     <= '0;
      calm        = 0;
      sent        = 0;
      idle_cycles = 0;
      now_ms      = 0;
      alt_level   = 10000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, except that the fallen state is kept out of reach: it only
      // leaves on reset, so it belongs at the very end of the run
      load_thresholds(93711, 1626913, 0, 44'd22500000000, 900000000, 40, 30, 5000);

      // directed: first rate sample at extremes, then the opposite extremes
      // inside a short rate window
      send_sample(make_sample(-16384, -16384, -16384, -2097152, -2097152, -2097152,
                              -1048576, 0));
      send_sample(make_sample(16383, 16383, 16383, 2097151, 2097151, 2097151,
                              1048575, 100));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 600));
      // averaged window settles near zero: free fall, then time it out
      send_sample(make_sample(0, 0, 0, 0, 0, 0, -200, 700));
      send_sample(make_sample(10, -10, 5, 0, 0, 0, -400, 900));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, -600, 3000));
      send_sample(make_sample(0, 0, 1000, 0, 0, 0, -600, 3100));
      // timestamp wrap across a rate window
      send_sample(make_sample(0, 0, 1000, 0, 0, 0, 500, 32'hFFFF_FF00));
      send_sample(make_sample(0, 0, 1000, 0, 0, 0, 900, 32'h0000_0200));
      // free fall across the wrap, impact, tumble, long wait back to idle
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 2000, 32'hFFFF_FFA0));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 1900, 32'hFFFF_FFF0));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 1500, 32'h0000_0100));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 1200, 32'h0000_0300));
      send_sample(make_sample(16000, 0, 16000, 1000000, 0, 0, 1000, 32'h0000_0400));
      send_sample(make_sample(-16000, 0, -16000, 2000000, 2000000, 2000000, 900,
                              32'h0000_0500));
      send_sample(make_sample(0, 0, 1000, 0, 0, 0, 800, 32'h0000_1000));
      send_sample(make_sample(0, 0, 1000, 0, 0, 0, 800, 32'h0000_2000));
      now_ms = 32'h0000_3000;
      repeat (4) send_fall_attempt();
      run_random(200);

      // low extremes: no free fall ever, instant decisions, any change is rapid
      load_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(150);

      // high extremes written as all ones, with bits above the width of each narrower register; moving level stays zero
      load_thresholds(ALL_ONES, ALL_ONES, 0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                      ALL_ONES);
      run_random(150);

      // random mid-range settings
      load_thresholds($urandom_range(20000, 400000), $urandom_range(500000, 4000000), 0,
                      CSR_W'(64'($urandom_range(100000000, 2000000000))
                             * 64'($urandom_range(1, 50))),
                      $urandom_range(100000000, 2000000000), $urandom_range(0, 500),
                      $urandom_range(0, 200), $urandom_range(0, 8000));
      run_random(250);

      // last phase: fallen reachable, no idling in its second half
      load_thresholds(93711, 1626913, ALL_ONES, 44'd22500000000, 900000000, 40, 30, 5000);
      run_random(150);
      calm = 1;
      run_random(150);

      wait_drained();
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/fdsm_pkg.sv
rtl/core/fdsm_if.sv
rtl/core/fdsm_front.sv
rtl/core/fdsm_queue.sv
rtl/core/fdsm_back.sv
rtl/core/fall_detection_state_machine_unit.sv
verif/tb_fall_detection_state_machine_unit.sv
